// File: src/nmea_gga_time_extractor_unit_defines.svh
// Assertion macros used by the NMEA GGA time extractor parser.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef NMEA_GGA_TIME_EXTRACTOR_UNIT_DEFINES_SVH
`define NMEA_GGA_TIME_EXTRACTOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the trigger.
`define NGET_ASSERT_NOW(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define NGET_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

// File: src/nget_pkg.sv
// Package for the NMEA GGA time extractor: character codes, parser phases,
// result struct and the small arithmetic helpers. No dependencies.
package nget_pkg;

    localparam int CAPTURE_LIMIT_DEFAULT = 16;
    localparam int DIGIT_COUNT           = 6;
    localparam int APB_ADDR_W            = 3;
    localparam int APB_DATA_W            = 32;

    localparam logic [3:0] TZ_HOURS_RESET = 4'd4;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    localparam logic [7:0] HEX_DIGIT_MAX    = 8'h39;
    localparam logic [7:0] HEX_ALPHA_OFFSET = 8'h37;
    localparam logic [7:0] HOURS_HALF_DAY   = 8'd12;
    localparam int         CONVERT_MIN_COUNT = 7;

    // Register index of tz_hours (paddr[2] selects the register).
    localparam logic REG_TZ_HOURS = 1'b0;

    typedef enum logic [10:0] {
        PH_HUNT   = 11'b000_0000_0001,
        PH_G1     = 11'b000_0000_0010,
        PH_P      = 11'b000_0000_0100,
        PH_G2     = 11'b000_0000_1000,
        PH_G3     = 11'b000_0001_0000,
        PH_A      = 11'b000_0010_0000,
        PH_COMMA  = 11'b000_0100_0000,
        PH_TIME   = 11'b000_1000_0000,
        PH_STAR   = 11'b001_0000_0000,
        PH_CK_HI  = 11'b010_0000_0000,
        PH_CK_LO  = 11'b100_0000_0000
    } phase_t;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } result_t;

    function automatic logic [7:0] digit_pair_value(digit_t tens, digit_t ones);
        return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
    endfunction

    function automatic digit_t hex_nibble(logic [7:0] c);
        logic [7:0] adj;
        adj = (c > HEX_DIGIT_MAX) ? c - HEX_ALPHA_OFFSET : c;
        return adj[3:0];
    endfunction

    // UTC hour digits to local 12-hour digits {tens, ones}. The subtraction
    // may go below zero for large tz; that case counts as above nine.
    function automatic logic [7:0] to_local_hour(digit_t tens, digit_t ones,
                                                 logic [3:0] tz);
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] h2;
        logic [8:0] h3;
        logic [8:0] h4;
        logic       over9;
        h0 = digit_pair_value(tens, ones);
        h1 = (h0 > HOURS_HALF_DAY) ? h0 - HOURS_HALF_DAY : h0;
        h2 = (h1 <= {4'b0000, tz}) ? h1 + HOURS_HALF_DAY : h1;
        h3 = {1'b0, h2} - {5'b00000, tz};
        over9 = h3[8] || (h3[7:0] > 8'd9);
        h4 = h3 - 9'd10;
        return over9 ? {4'd1, h4[3:0]} : {4'd0, h3[3:0]};
    endfunction

endpackage

// File: src/nget_ifs.sv
// Stream interfaces of the NMEA GGA time extractor: received bytes in,
// decoded time out. Depends on nothing.
interface nget_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nget_time_if;
    logic       valid;
    logic       ready;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;

    modport source (output valid, output hour, output minute, output second, input ready);
    modport sink   (input valid, input hour, input minute, input second, output ready);
endinterface

// File: src/nmea_gga_time_extractor_unit.sv
// NMEA GGA time extractor: accepts one received byte per clock and reports
// local hour, minute and second when a GGA sentence with a good checksum
// carries a new time. A byte passes an input register, the parser updates
// its state from it, and any result lands in an output register. The input side
// stays ready while the output register is free or being emptied; only a result
// that the sink does not take stops the flow. tz_hours sits at APB address 0.
// Depends on nget_pkg, nget_ifs, nget_apb_regs and nget_parser.
module nmea_gga_time_extractor_unit #(
    parameter int CAPTURE_LIMIT = nget_pkg::CAPTURE_LIMIT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    nget_rx_if.sink                           rx_chan,
    nget_time_if.source                       time_chan,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nget_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nget_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nget_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              advance;
    logic [3:0]        tz_hours;
    nget_pkg::result_t res;
    logic              out_valid_reg;
    logic [7:0]        hour_reg;
    logic [7:0]        minute_reg;
    logic [7:0]        second_reg;

    nget_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .tz_hours (tz_hours)
    );

    nget_parser #(
        .CAPTURE_LIMIT (CAPTURE_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (advance),
        .item_byte (in_byte_reg),
        .tz_hours  (tz_hours),
        .result    (res)
    );

    // A byte moves into the parser when the output register can take a result.
    assign advance       = in_valid_reg && (!out_valid_reg || time_chan.ready);
    assign rx_chan.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_chan.ready)
        begin
            in_valid_reg <= rx_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_chan.ready && rx_chan.valid)
        begin
            in_byte_reg <= rx_chan.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (time_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            hour_reg   <= res.hour;
            minute_reg <= res.minute;
            second_reg <= res.second;
        end
    end

    assign time_chan.valid  = out_valid_reg;
    assign time_chan.hour   = hour_reg;
    assign time_chan.minute = minute_reg;
    assign time_chan.second = second_reg;

endmodule

// File: src/nget_apb_regs.sv
// APB-style configuration register of the NMEA GGA time extractor (tz_hours).
// Depends on nget_pkg.
module nget_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nget_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nget_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nget_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [3:0]                          tz_hours
);

    logic [3:0] tz_reg;
    logic       wr_tz;

    assign pready = 1'b1;
    assign wr_tz  = psel && penable && pwrite && (paddr[2] == nget_pkg::REG_TZ_HOURS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg <= nget_pkg::TZ_HOURS_RESET;
        end
        else if (wr_tz)
        begin
            tz_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == nget_pkg::REG_TZ_HOURS)
        begin
            prdata[3:0] = tz_reg;
        end
    end

    assign tz_hours = tz_reg;

endmodule

// File: src/nget_parser.sv
// Sentence parser of the NMEA GGA time extractor: header match, time field
// capture, hour conversion, checksum and change detection.
// Depends on nget_pkg and the assertion macro header.
`include "nmea_gga_time_extractor_unit_defines.svh"

module nget_parser #(
    parameter int CAPTURE_LIMIT = nget_pkg::CAPTURE_LIMIT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_fire,
    input  logic [7:0]          item_byte,
    input  logic [3:0]          tz_hours,
    output nget_pkg::result_t   result
);

    localparam int CNT_W = $clog2(CAPTURE_LIMIT + 1);

    nget_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       cap_sum_reg, cap_sum_next;
    logic [3:0]       rcv_hi_reg, rcv_hi_next;
    logic [CNT_W-1:0] count_reg, count_next;
    nget_pkg::digit_t digits_reg [nget_pkg::DIGIT_COUNT];
    nget_pkg::digit_t digits_next [nget_pkg::DIGIT_COUNT];
    nget_pkg::digit_t last_reg [nget_pkg::DIGIT_COUNT];
    nget_pkg::digit_t last_next [nget_pkg::DIGIT_COUNT];

    logic       sum_match;
    logic       digits_differ;
    logic [7:0] local_hour;

    always_comb
    begin
        digits_differ = 1'b0;
        for (int i = 0; i < nget_pkg::DIGIT_COUNT; i++)
        begin
            if (digits_reg[i] != last_reg[i])
            begin
                digits_differ = 1'b1;
            end
        end
    end

    assign sum_match  = (cap_sum_reg == {rcv_hi_reg, nget_pkg::hex_nibble(item_byte)});
    assign local_hour = nget_pkg::to_local_hour(digits_reg[0], digits_reg[1], tz_hours);

    always_comb
    begin
        phase_next   = phase_reg;
        xor_next     = (item_byte != nget_pkg::CHAR_STAR) ? xor_reg ^ item_byte : xor_reg;
        cap_sum_next = cap_sum_reg;
        rcv_hi_next  = rcv_hi_reg;
        count_next   = count_reg;
        digits_next  = digits_reg;
        last_next    = last_reg;
        result       = '0;

        unique case (phase_reg)
            nget_pkg::PH_HUNT:
            begin
                xor_next   = '0;
                phase_next = (item_byte == nget_pkg::CHAR_DOLLAR) ? nget_pkg::PH_G1
                                                                   : nget_pkg::PH_HUNT;
            end
            nget_pkg::PH_G1:
            begin
                phase_next = (item_byte == nget_pkg::CHAR_G) ? nget_pkg::PH_P
                                                              : nget_pkg::PH_HUNT;
            end
            nget_pkg::PH_P:
            begin
                phase_next = (item_byte == nget_pkg::CHAR_P) ? nget_pkg::PH_G2
                                                              : nget_pkg::PH_HUNT;
            end
            nget_pkg::PH_G2:
            begin
                phase_next = (item_byte == nget_pkg::CHAR_G) ? nget_pkg::PH_G3
                                                              : nget_pkg::PH_HUNT;
            end
            nget_pkg::PH_G3:
            begin
                phase_next = (item_byte == nget_pkg::CHAR_G) ? nget_pkg::PH_A
                                                              : nget_pkg::PH_HUNT;
            end
            nget_pkg::PH_A:
            begin
                phase_next = (item_byte == nget_pkg::CHAR_A) ? nget_pkg::PH_COMMA
                                                              : nget_pkg::PH_HUNT;
            end
            nget_pkg::PH_COMMA:
            begin
                count_next = '0;
                phase_next = (item_byte == nget_pkg::CHAR_COMMA) ? nget_pkg::PH_TIME
                                                                  : nget_pkg::PH_HUNT;
            end
            nget_pkg::PH_TIME:
            begin
                if (item_byte == nget_pkg::CHAR_COMMA)
                begin
                    // A full hhmmss.s field or longer gets the local-time rewrite.
                    if (count_reg > CNT_W'(nget_pkg::CONVERT_MIN_COUNT))
                    begin
                        digits_next[0] = local_hour[7:4];
                        digits_next[1] = local_hour[3:0];
                    end
                    count_next = '0;
                    phase_next = nget_pkg::PH_STAR;
                end
                else if (count_reg < CNT_W'(CAPTURE_LIMIT))
                begin
                    for (int i = 0; i < nget_pkg::DIGIT_COUNT; i++)
                    begin
                        if (count_reg == CNT_W'(i))
                        begin
                            digits_next[i] = item_byte[3:0];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            nget_pkg::PH_STAR:
            begin
                if (item_byte == nget_pkg::CHAR_STAR)
                begin
                    cap_sum_next = xor_reg;
                    phase_next   = nget_pkg::PH_CK_HI;
                end
            end
            nget_pkg::PH_CK_HI:
            begin
                rcv_hi_next = nget_pkg::hex_nibble(item_byte);
                phase_next  = nget_pkg::PH_CK_LO;
            end
            nget_pkg::PH_CK_LO:
            begin
                if (sum_match && digits_differ)
                begin
                    last_next     = digits_reg;
                    result.valid  = 1'b1;
                    result.hour   = nget_pkg::digit_pair_value(digits_reg[0], digits_reg[1]);
                    result.minute = nget_pkg::digit_pair_value(digits_reg[2], digits_reg[3]);
                    result.second = nget_pkg::digit_pair_value(digits_reg[4], digits_reg[5]);
                end
                for (int i = 0; i < nget_pkg::DIGIT_COUNT; i++)
                begin
                    digits_next[i] = '0;
                end
                phase_next = nget_pkg::PH_HUNT;
            end
            default:
            begin
                phase_next = nget_pkg::PH_HUNT;
            end
        endcase

        if (!item_fire)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= nget_pkg::PH_HUNT;
            xor_reg     <= '0;
            cap_sum_reg <= '0;
            rcv_hi_reg  <= '0;
            count_reg   <= '0;
            for (int i = 0; i < nget_pkg::DIGIT_COUNT; i++)
            begin
                digits_reg[i] <= '0;
                last_reg[i]   <= '0;
            end
        end
        else if (item_fire)
        begin
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            cap_sum_reg <= cap_sum_next;
            rcv_hi_reg  <= rcv_hi_next;
            count_reg   <= count_next;
            digits_reg  <= digits_next;
            last_reg    <= last_next;
        end
    end

    `NGET_ASSERT_NOW(a_result_only_at_sum, result.valid, item_fire && (phase_reg == nget_pkg::PH_CK_LO), "result outside the checksum phase")
    `NGET_ASSERT_NEXT(a_sentence_end_clears, item_fire && (phase_reg == nget_pkg::PH_CK_LO), (phase_reg == nget_pkg::PH_HUNT) && (digits_reg[0] == 4'd0) && (digits_reg[5] == 4'd0), "sentence end did not clear the parser")
    `NGET_ASSERT_NEXT(a_result_stores_digits, result.valid, (last_reg[2] == $past(digits_reg[2])) && (last_reg[4] == $past(digits_reg[4])), "reported digits not stored")
    `NGET_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(CAPTURE_LIMIT), "field count past capture limit")

endmodule
